[rtl/core/scrdp_pkg.sv]
// Shared types and constants for the SCReLU dot product accumulator.
package scrdp_pkg;

    localparam int VALUE_W  = 16;
    localparam int CEIL_W   = 15;
    localparam int SUM_W    = 32;
    localparam int FIFO_DEPTH_DEFAULT = 4;

    localparam logic [CEIL_W-1:0] CEILING_RESET = 15'd255;

    // One classified element: clamped activations, their weights and the end mark.
    typedef struct packed {
        logic                      last;
        logic [CEIL_W-1:0]         c_us;
        logic [CEIL_W-1:0]         c_them;
        logic signed [VALUE_W-1:0] w_us;
        logic signed [VALUE_W-1:0] w_them;
    } elem_t;

    // Clamp a signed value to [0, ceiling].
    function automatic logic [CEIL_W-1:0] clamp_act(
        input logic signed [VALUE_W-1:0] v,
        input logic [CEIL_W-1:0]         ceiling
    );
        logic [CEIL_W-1:0] r;
        if (v[VALUE_W-1]) begin
            r = '0;
        end else if (v[CEIL_W-1:0] > ceiling) begin
            r = ceiling;
        end else begin
            r = v[CEIL_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/scrdp_front.sv]
// Front end: ceiling register, item intake and activation clamping.
module scrdp_front
    import scrdp_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CEIL_W-1:0]         cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [VALUE_W-1:0] s_us_value,
    input  logic signed [VALUE_W-1:0] s_them_value,
    input  logic signed [VALUE_W-1:0] s_us_weight,
    input  logic signed [VALUE_W-1:0] s_them_weight,
    input  logic                      s_last,
    output logic                      push_valid,
    input  logic                      push_ready,
    output elem_t                     push_data
);

    logic [CEIL_W-1:0] ceiling_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ceiling_reg <= CEILING_RESET;
        end else if (cfg_valid) begin
            ceiling_reg <= cfg_data;
        end
    end

    assign cfg_ready  = 1'b1;
    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        push_data.last   = s_last;
        push_data.c_us   = clamp_act(s_us_value, ceiling_reg);
        push_data.c_them = clamp_act(s_them_value, ceiling_reg);
        push_data.w_us   = s_us_weight;
        push_data.w_them = s_them_weight;
    end

endmodule

[rtl/core/scrdp_fifo.sv]
// Short queue of classified elements between front and back end.
module scrdp_fifo
    import scrdp_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEFAULT
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  elem_t push_data,
    output logic  pop_valid,
    input  logic  pop_ready,
    output elem_t pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    elem_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

[rtl/core/scrdp_back.sv]
// Back end: two shared multipliers, running sum and result register.
module scrdp_back
    import scrdp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  elem_t                   pop_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [SUM_W-1:0] m_evaluation
);

    typedef enum logic {
        PH_MUL_CW,
        PH_MUL_TC
    } phase_t;

    phase_t                    phase_reg;
    logic                      op_valid_reg;
    logic                      op_last_reg;
    logic [CEIL_W-1:0]         c_us_reg;
    logic [CEIL_W-1:0]         c_them_reg;
    logic signed [VALUE_W-1:0] w_us_reg;
    logic signed [VALUE_W-1:0] w_them_reg;
    logic signed [VALUE_W-1:0] t_us_reg;
    logic signed [VALUE_W-1:0] t_them_reg;
    logic                      p_valid_reg;
    logic                      p_last_reg;
    logic signed [SUM_W-1:0]   p_us_reg;
    logic signed [SUM_W-1:0]   p_them_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic [SUM_W-1:0]          sum_next;
    logic                      m_valid_reg;
    logic [SUM_W-1:0]          m_evaluation_reg;

    logic signed [VALUE_W-1:0] mul_a_us;
    logic signed [VALUE_W-1:0] mul_a_them;
    logic signed [SUM_W-1:0]   prod_us;
    logic signed [SUM_W-1:0]   prod_them;
    logic                      acc_go;
    logic                      p_free;
    logic                      op_done;
    logic                      pop;

    // Each multiplier runs c * w first, then t * c for the same element.
    assign mul_a_us   = (phase_reg == PH_MUL_TC) ? t_us_reg : w_us_reg;
    assign mul_a_them = (phase_reg == PH_MUL_TC) ? t_them_reg : w_them_reg;
    assign prod_us    = SUM_W'(mul_a_us) * SUM_W'($signed({1'b0, c_us_reg}));
    assign prod_them  = SUM_W'(mul_a_them) * SUM_W'($signed({1'b0, c_them_reg}));

    assign sum_next = sum_reg + p_us_reg + p_them_reg;

    // A closing sum waits while the result register is still occupied.
    assign acc_go    = p_valid_reg && (!p_last_reg || !m_valid_reg || m_ready);
    assign p_free    = !p_valid_reg || acc_go;
    assign op_done   = op_valid_reg && (phase_reg == PH_MUL_TC) && p_free;
    assign pop       = pop_valid && (!op_valid_reg || op_done);
    assign pop_ready = !op_valid_reg || op_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_MUL_CW;
            op_valid_reg <= 1'b0;
            p_valid_reg  <= 1'b0;
            sum_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (pop) begin
                c_us_reg    <= pop_data.c_us;
                c_them_reg  <= pop_data.c_them;
                w_us_reg    <= pop_data.w_us;
                w_them_reg  <= pop_data.w_them;
                op_last_reg <= pop_data.last;
            end

            unique case (phase_reg)
                PH_MUL_CW: begin
                    if (op_valid_reg) begin
                        // Keep the low 16 bits of c * w.
                        t_us_reg   <= prod_us[VALUE_W-1:0];
                        t_them_reg <= prod_them[VALUE_W-1:0];
                        phase_reg  <= PH_MUL_TC;
                    end else begin
                        op_valid_reg <= pop;
                    end
                end
                PH_MUL_TC: begin
                    if (op_done) begin
                        p_us_reg     <= prod_us;
                        p_them_reg   <= prod_them;
                        p_last_reg   <= op_last_reg;
                        phase_reg    <= PH_MUL_CW;
                        op_valid_reg <= pop;
                    end
                end
                default: begin
                    phase_reg <= PH_MUL_CW;
                end
            endcase

            if (op_done) begin
                p_valid_reg <= 1'b1;
            end else if (acc_go) begin
                p_valid_reg <= 1'b0;
            end

            if (acc_go && p_last_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (acc_go) begin
                if (p_last_reg) begin
                    m_evaluation_reg <= sum_next;
                    sum_reg          <= '0;
                end else begin
                    sum_reg <= sum_next;
                end
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_evaluation = $signed(m_evaluation_reg);

endmodule

[rtl/core/screlu_dot_product_accumulator_core.sv]
// Top level of the SCReLU dot product accumulator.
//
// Each item carries one hidden element for both sides with its two output weights.
// The front end clamps both values to [0, ceiling] and queues the element; the back end
// forms (c * w truncated to 16 bits) * c for both sides on two multipliers and adds both
// terms to a wrapping 32-bit sum. The item marked last produces one result on the m_
// channel and clears the sum. Each of the two multipliers is used twice per element, and
// the back end pops the next element only as it finishes the current one. An item passes
// the queue and the operand, truncated and product registers into the result register.
// The queue holds FIFO_DEPTH items. The ceiling (reset 255) is written through the cfg_
// channel by the user only while no item is in flight; the block does not enforce it.
module screlu_dot_product_accumulator_core
    import scrdp_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CEIL_W-1:0]         cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [VALUE_W-1:0] s_us_value,
    input  logic signed [VALUE_W-1:0] s_them_value,
    input  logic signed [VALUE_W-1:0] s_us_weight,
    input  logic signed [VALUE_W-1:0] s_them_weight,
    input  logic                      s_last,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [SUM_W-1:0]   m_evaluation
);

    logic  push_valid;
    logic  push_ready;
    elem_t push_data;
    logic  pop_valid;
    logic  pop_ready;
    elem_t pop_data;

    scrdp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_us_value    (s_us_value),
        .s_them_value  (s_them_value),
        .s_us_weight   (s_us_weight),
        .s_them_weight (s_them_weight),
        .s_last        (s_last),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    scrdp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    scrdp_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_evaluation (m_evaluation)
    );

endmodule

[rtl/core/scrdp_checker.sv]
// Port-level checks for the SCReLU dot product accumulator, bound to the top level.
module scrdp_checker
    import scrdp_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic signed [VALUE_W-1:0] s_us_value,
    input logic signed [VALUE_W-1:0] s_them_value,
    input logic signed [VALUE_W-1:0] s_us_weight,
    input logic signed [VALUE_W-1:0] s_them_weight,
    input logic                      s_last,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [SUM_W-1:0]   m_evaluation
);

    // Hold a stalled result unchanged.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_evaluation))
        else $error("result changed or dropped while stalled");

    // A waiting input item keeps valid and payload.
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid &&
            $stable({s_us_value, s_them_value, s_us_weight, s_them_weight, s_last}))
        else $error("input item changed or dropped while stalled");

    a_reset_no_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("queue not empty after reset");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind screlu_dot_product_accumulator_core scrdp_checker u_scrdp_checker (.*);
